// File: design/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared constants, field positions and controller/datapath interface types
// for the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  // Digit store geometry and limits
  localparam int DIGIT_DEPTH = 32;
  localparam int MAX_FIELD   = 63;
  localparam int PREC_LIMIT  = (32 < DIGIT_DEPTH) ? 32 : DIGIT_DEPTH;
  localparam int DADDR_W     = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
  localparam int PTR_DIGITS  = 8;

  // Input packing
  localparam int VALUE_W = 32;
  localparam int CONV_W  = 3;
  localparam int WIDTH_W = 6;
  localparam int PREC_W  = 7;
  localparam int IN_DATA_W = 48;
  localparam int IN_USER_W = 2;
  localparam int VALUE_LSB = 0;
  localparam int CONV_LSB  = VALUE_LSB + VALUE_W;
  localparam int WIDTH_LSB = CONV_LSB + CONV_W;
  localparam int PREC_LSB  = WIDTH_LSB + WIDTH_W;
  localparam int USER_LEFT = 0;
  localparam int USER_ZERO = 1;
  localparam int CHAR_W    = 8;

  // Conversion codes
  localparam logic [CONV_W-1:0] CONV_DI    = 3'd0;
  localparam logic [CONV_W-1:0] CONV_U     = 3'd1;
  localparam logic [CONV_W-1:0] CONV_XLOW  = 3'd2;
  localparam logic [CONV_W-1:0] CONV_XUP   = 3'd3;
  localparam logic [CONV_W-1:0] CONV_OCT   = 3'd4;
  localparam logic [CONV_W-1:0] CONV_PTR   = 3'd5;

  // Radix codes
  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_HEX = 2'd1;
  localparam logic [1:0] BASE_OCT = 2'd2;

  // Reciprocal of ten: floor(v / 10) = (v * RECIP10) >> RECIP10_SHIFT for 32-bit v
  localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int                 RECIP10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CHAR_W-1:0] HEX_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [CHAR_W-1:0] HEX_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_X,
    SEL_PAD,
    SEL_MINUS,
    SEL_DIGIT
  } char_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      mul;
    logic      div_wr;
    logic      zero_wr;
    logic      pad_load;
    logic      pad_dec;
    logic      cnt_dec;
    logic      rd;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
    logic v_zero;
    logic cnt_below_min;
    logic cnt_zero;
    logic cnt_one;
    logic pad_zero;
    logic pad_one;
    logic ptr;
    logic zp;
    logic neg;
    logic left;
    logic out_free;
  } stat_t;

endpackage

// File: design/ifmt_ctrl.sv
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Sequencer: digit generation loop, then the character segments of the field
// (prefix, padding, sign, digits, trailing padding) one transfer at a time.
// ----------------------------------------------------------------------------
module ifmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ifmt_pkg::stat_t st,
  output ifmt_pkg::cmd_t  cmd
);
  import ifmt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_WR   = 4'd2;
  localparam logic [3:0] S_DISP = 4'd3;
  localparam logic [3:0] S_PFX0 = 4'd4;
  localparam logic [3:0] S_PFX1 = 4'd5;
  localparam logic [3:0] S_LPAD = 4'd6;
  localparam logic [3:0] S_SIGN = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;
  localparam logic [3:0] S_DEM  = 4'd9;
  localparam logic [3:0] S_RPAD = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [3:0] rpad_or_end, dig_or_end, after_lpad, after_sign, first_seg;

  always_comb begin
    rpad_or_end = (st.left && !st.pad_zero) ? S_RPAD : S_IDLE;
    dig_or_end  = st.cnt_zero ? rpad_or_end : S_DRD;
    after_lpad  = (!st.zp && st.neg) ? S_SIGN : dig_or_end;
    after_sign  = (st.zp && !st.pad_zero) ? S_LPAD : dig_or_end;
    if (st.ptr) begin
      first_seg = S_PFX0;
    end else if (st.zp) begin
      first_seg = st.neg ? S_SIGN : (st.pad_zero ? dig_or_end : S_LPAD);
    end else if (!st.left && !st.pad_zero) begin
      first_seg = S_LPAD;
    end else begin
      first_seg = st.neg ? S_SIGN : dig_or_end;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_PAD;
    // no transfer is taken while reset is held
    in_tready = (state_r == S_IDLE) && rst_n;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && !st.in_bad) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (!st.v_zero) begin
          cmd.mul   = 1'b1;
          state_nxt = S_WR;
        end else if (st.cnt_below_min) begin
          cmd.zero_wr = 1'b1;
        end else begin
          cmd.pad_load = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_WR: begin
        cmd.div_wr = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DISP: begin
        state_nxt = first_seg;
      end
      S_PFX0: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_ZERO;
          state_nxt = S_PFX1;
        end
      end
      S_PFX1: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_X;
          state_nxt = S_DRD;
        end
      end
      S_LPAD: begin
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_PAD;
          cmd.pad_dec = 1'b1;
          if (st.pad_one) begin
            state_nxt = after_lpad;
          end
        end
      end
      S_SIGN: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_MINUS;
          state_nxt = after_sign;
        end
      end
      S_DRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DEM;
      end
      S_DEM: begin
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_DIGIT;
          cmd.cnt_dec = 1'b1;
          state_nxt   = st.cnt_one ? rpad_or_end : S_DRD;
        end
      end
      S_RPAD: begin
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_PAD;
          cmd.pad_dec = 1'b1;
          if (st.pad_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // the final character of the field is the one that returns to idle
    cmd.last = cmd.emit && (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/ifmt_dpath.sv
// ----------------------------------------------------------------------------
// ifmt_dpath
// Operand registers, radix divider (reciprocal multiply for decimal, shifts for
// hex and octal), digit store, padding counter and the output register.
// ----------------------------------------------------------------------------
module ifmt_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ifmt_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [ifmt_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ifmt_pkg::CHAR_W-1:0]    out_tdata,
  output logic                           out_tlast,
  input  ifmt_pkg::cmd_t                 cmd,
  output ifmt_pkg::stat_t                st
);
  import ifmt_pkg::*;

  // input unpacking
  logic [VALUE_W-1:0] in_value;
  logic [CONV_W-1:0]  in_conv;
  logic [WIDTH_W-1:0] in_width;
  logic [PREC_W-1:0]  in_prec;
  logic               in_left, in_zero, prec_absent, in_ptr, in_neg;
  logic [CNT_W-1:0]   prec_clamped;
  logic [WIDTH_W-1:0] width_clamped;

  assign in_value = in_tdata[VALUE_LSB +: VALUE_W];
  assign in_conv  = in_tdata[CONV_LSB  +: CONV_W];
  assign in_width = in_tdata[WIDTH_LSB +: WIDTH_W];
  assign in_prec  = in_tdata[PREC_LSB  +: PREC_W];
  assign in_left  = in_tuser[USER_LEFT];
  assign in_zero  = in_tuser[USER_ZERO];
  assign prec_absent = in_prec[PREC_W-1];
  assign in_ptr   = (in_conv == CONV_PTR);
  assign in_neg   = (in_conv == CONV_DI) && in_value[VALUE_W-1];

  always_comb begin
    if (in_prec[PREC_W-2:0] > (PREC_W-1)'(PREC_LIMIT)) begin
      prec_clamped = CNT_W'(PREC_LIMIT);
    end else begin
      prec_clamped = CNT_W'(in_prec[PREC_W-2:0]);
    end
    if (32'(in_width) > 32'(MAX_FIELD)) begin
      width_clamped = WIDTH_W'(MAX_FIELD);
    end else begin
      width_clamped = in_width;
    end
  end

  // operand registers
  logic [VALUE_W-1:0] v_r, q_r;
  logic [1:0]         base_r;
  logic               upper_r, ptr_r, zp_r, neg_r, left_r;
  logic [CNT_W-1:0]   min_r;
  logic [WIDTH_W-1:0] width_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [WIDTH_W-1:0] pad_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_r     <= in_neg ? (~in_value + 32'd1) : in_value;
      neg_r   <= in_neg;
      ptr_r   <= in_ptr;
      upper_r <= (in_conv == CONV_XUP);
      left_r  <= in_left && !in_ptr;
      zp_r    <= in_zero && !in_left && prec_absent && !in_ptr;
      width_r <= width_clamped;
      if (in_ptr) begin
        min_r <= CNT_W'(PTR_DIGITS);
      end else if (prec_absent) begin
        min_r <= CNT_W'(1);
      end else begin
        min_r <= prec_clamped;
      end
      if (in_ptr || in_conv == CONV_XLOW || in_conv == CONV_XUP) begin
        base_r <= BASE_HEX;
      end else if (in_conv == CONV_OCT) begin
        base_r <= BASE_OCT;
      end else begin
        base_r <= BASE_DEC;
      end
    end else if (cmd.div_wr) begin
      v_r <= q_r;
    end
  end

  // divide by the radix
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   q_nxt;
  logic [3:0]           radix_lo, rem;
  logic [7:0]           qmul;

  assign prod = (2*VALUE_W)'(v_r) * (2*VALUE_W)'(RECIP10);

  always_comb begin
    unique case (base_r)
      BASE_HEX: begin
        q_nxt    = v_r >> 4;
        radix_lo = 4'd0;
      end
      BASE_OCT: begin
        q_nxt    = v_r >> 3;
        radix_lo = 4'd8;
      end
      default: begin
        q_nxt    = VALUE_W'(prod >> RECIP10_SHIFT);
        radix_lo = 4'd10;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      q_r <= q_nxt;
    end
  end

  // remainder only needs the low nibble: v - q * radix mod 16
  assign qmul = q_r[3:0] * radix_lo;
  assign rem  = v_r[3:0] - qmul[3:0];

  // digit store
  logic [3:0]         mem [DIGIT_DEPTH];
  logic [3:0]         rd_q;
  logic [DADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]   cnt_m1;

  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign rd_addr = cnt_m1[DADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_wr || cmd.zero_wr) begin
      mem[cnt_r[DADDR_W-1:0]] <= cmd.div_wr ? rem : 4'd0;
    end
    if (cmd.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // digit and pad counters
  logic [WIDTH_W:0] total, width_ext;

  assign total     = (WIDTH_W+1)'(cnt_r) + (WIDTH_W+1)'(neg_r);
  assign width_ext = (WIDTH_W+1)'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pad_r <= '0;
    end else begin
      if (cmd.load_in) begin
        cnt_r <= '0;
      end else if (cmd.div_wr || cmd.zero_wr) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.pad_load) begin
        if (!ptr_r && width_ext > total) begin
          pad_r <= WIDTH_W'(width_ext - total);
        end else begin
          pad_r <= '0;
        end
      end else if (cmd.pad_dec) begin
        pad_r <= pad_r - WIDTH_W'(1);
      end
    end
  end

  // output register
  logic                out_valid_r, out_last_r;
  logic [CHAR_W-1:0]   out_char_r, char_nxt;

  always_comb begin
    unique case (cmd.sel)
      SEL_ZERO:  char_nxt = CH_ZERO;
      SEL_X:     char_nxt = CH_X;
      SEL_MINUS: char_nxt = CH_MINUS;
      SEL_DIGIT: char_nxt = upper_r ? HEX_UPPER[rd_q] : HEX_LOWER[rd_q];
      SEL_PAD:   char_nxt = zp_r ? CH_ZERO : CH_SPACE;
      default:   char_nxt = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= char_nxt;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // status
  assign st.in_bad        = (in_conv > CONV_PTR);
  assign st.v_zero        = (v_r == '0);
  assign st.cnt_below_min = (cnt_r < min_r);
  assign st.cnt_zero      = (cnt_r == '0);
  assign st.cnt_one       = (cnt_r == CNT_W'(1));
  assign st.pad_zero      = (pad_r == '0);
  assign st.pad_one       = (pad_r == WIDTH_W'(1));
  assign st.ptr           = ptr_r;
  assign st.zp            = zp_r;
  assign st.neg           = neg_r;
  assign st.left          = left_r;
  assign st.out_free      = !out_valid_r || out_tready;

endmodule

// File: design/integer_field_formatter_core.sv
// Sequence: accept, then per significant digit a multiply (S_DIV) and a store
//   (S_WR), per zero-extended digit a store, then leave the loop and dispatch;
//   then pad, sign and prefix characters are emitted from their own states and
//   digit characters by a read and then an emit, each into the output register.
//   One field at a time; output stalls hold the sequence.
// Reset: synchronous, active low; controller idles, output register empties.
// ----------------------------------------------------------------------------
// integer_field_formatter_core
// Renders one parsed integer conversion as a stream of ASCII characters.
// ----------------------------------------------------------------------------
module integer_field_formatter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // value[31:0], conversion[34:32], field_width[40:35], precision[47:41]
  input  logic [ifmt_pkg::IN_DATA_W-1:0] in_tdata,
  // left_justify[0], zero_pad[1]
  input  logic [ifmt_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_char[7:0]
  output logic [ifmt_pkg::CHAR_W-1:0]    out_tdata,
  output logic                           out_tlast
);
  import ifmt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ifmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ifmt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

// File: design/ifmt_chk.sv
// ----------------------------------------------------------------------------
// ifmt_chk
// Port-level checks for the integer field formatter, bound to the top level.
// ----------------------------------------------------------------------------
module ifmt_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [ifmt_pkg::IN_DATA_W-1:0] in_tdata,
  input logic [ifmt_pkg::IN_USER_W-1:0] in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ifmt_pkg::CHAR_W-1:0]    out_tdata,
  input logic                           out_tlast
);
  import ifmt_pkg::*;

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // a valid conversion occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[CONV_LSB +: CONV_W] <= CONV_PTR) |=> !in_tready)
    else $error("ready after accepting a valid conversion");

  // while ready, only the final character of the previous field may wait
  a_idle_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("block idle with a field unfinished");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind integer_field_formatter_core ifmt_chk u_ifmt_chk (.*);

// File: dv/integer_field_formatter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_formatter_core_tb
// Feeds parsed integer conversions into the formatter and checks every output
// character and its last marker against a field renderer held in the bench.
// ----------------------------------------------------------------------------
module integer_field_formatter_core_tb;
  import ifmt_pkg::*;

  localparam int RANDOM_FIELDS = 198;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 256;

  // conversion codes that the block ignores
  localparam logic [CONV_W-1:0] CONV_SPARE_LO = 3'd6;
  localparam logic [CONV_W-1:0] CONV_SPARE_HI = 3'd7;
  localparam logic [PREC_W-1:0] PREC_ABSENT   = 7'h7F;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [CONV_W-1:0]  conv;
    logic [WIDTH_W-1:0] width;
    logic [PREC_W-1:0]  prec;
    logic               left;
    logic               zero;
    bit                 drain_first;
  } conv_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } field_char_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_PULSE} sink_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [CHAR_W-1:0]    out_tdata;
  logic                 out_tlast;

  conv_req_t   pending_reqs[$];
  field_char_t expected_chars[$];
  logic [3:0]  digit_mem [DIGIT_DEPTH];
  int          reqs_queued = 0;
  int          reqs_sent = 0;
  int          reqs_taken = 0;
  int          quiet_cycles = 0;
  int          errors = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  sink_mode_t  sink_mode = SINK_OPEN;
  bit [7:0]    sink_left = '0;

  integer_field_formatter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Render one accepted conversion into the characters it must produce.
  function automatic void render_field(input logic [IN_DATA_W-1:0] word,
                                       input logic [IN_USER_W-1:0] flags);
    logic [VALUE_W-1:0] mag;
    logic [CONV_W-1:0]  conv;
    int                 width;
    int                 prec;
    int                 radix;
    int                 ndig;
    int                 pad;
    bit                 neg;
    bit                 left_j;
    bit                 zmode;
    bit                 upper;
    logic [CHAR_W-1:0]  line[$];
    mag    = word[VALUE_LSB +: VALUE_W];
    conv   = word[CONV_LSB +: CONV_W];
    width  = int'(word[WIDTH_LSB +: WIDTH_W]);
    prec   = word[PREC_LSB + PREC_W - 1] ? -1 : int'(word[PREC_LSB +: PREC_W]);
    left_j = flags[USER_LEFT];
    neg    = 1'b0;
    radix  = 10;
    upper  = (conv == CONV_XUP);
    if (conv > CONV_PTR) return;
    if (prec > PREC_LIMIT) prec = PREC_LIMIT;
    if (width > MAX_FIELD) width = MAX_FIELD;
    case (conv)
      CONV_DI: begin
        if (mag[VALUE_W-1]) begin
          neg = 1'b1;
          mag = -mag;
        end
      end
      CONV_XLOW, CONV_XUP: radix = 16;
      CONV_OCT: radix = 8;
      CONV_PTR: begin
        // fixed shape: prefix and eight hex digits, flags and width dropped
        radix  = 16;
        prec   = PTR_DIGITS;
        width  = 0;
        left_j = 1'b0;
        line.push_back(CH_ZERO);
        line.push_back(CH_X);
      end
      default: ;
    endcase
    zmode = flags[USER_ZERO] && !left_j && prec < 0;

    ndig = 0;
    if (mag == '0 && prec != 0) begin
      digit_mem[ndig] = 4'd0;
      ndig++;
    end
    while (mag != '0 && ndig < DIGIT_DEPTH) begin
      digit_mem[ndig] = 4'(mag % radix);
      mag = mag / radix;
      ndig++;
    end
    while (ndig < prec && ndig < DIGIT_DEPTH) begin
      digit_mem[ndig] = 4'd0;
      ndig++;
    end

    pad = width - ndig - int'(neg);
    if (pad < 0) pad = 0;

    if (!left_j && !zmode) repeat (pad) line.push_back(CH_SPACE);
    if (neg) line.push_back(CH_MINUS);
    if (zmode) repeat (pad) line.push_back(CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--)
      line.push_back(upper ? HEX_UPPER[digit_mem[i]] : HEX_LOWER[digit_mem[i]]);
    if (left_j) repeat (pad) line.push_back(CH_SPACE);

    for (int i = 0; i < line.size(); i++)
      expected_chars.push_back('{ch: line[i], last: (i == line.size() - 1)});
  endfunction

  task automatic queue_conv(input logic [VALUE_W-1:0] value, input logic [CONV_W-1:0] conv,
                            input logic [WIDTH_W-1:0] width, input logic [PREC_W-1:0] prec,
                            input logic left, input logic zero, input bit drain_first);
    conv_req_t req;
    req.value       = value;
    req.conv        = conv;
    req.width       = width;
    req.prec        = prec;
    req.left        = left;
    req.zero        = zero;
    req.drain_first = drain_first;
    pending_reqs.push_back(req);
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && reqs_taken != reqs_sent) begin
      // hold until the transfer completes
    end else if (gap_left > 0) begin
      gap_left  <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (pending_reqs.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (pending_reqs[0].drain_first && expected_chars.size() != 0) begin
      in_tvalid <= 1'b0;
    end else begin
      in_tdata  <= {pending_reqs[0].prec, pending_reqs[0].width, pending_reqs[0].conv,
                    pending_reqs[0].value};
      in_tuser  <= {pending_reqs[0].zero, pending_reqs[0].left};
      in_tvalid <= 1'b1;
      reqs_sent <= reqs_sent + 1;
      void'(pending_reqs.pop_front());
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 10);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver: stall pattern changes mode every so often.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = 8'($urandom_range(16, 200));
    end else begin
      sink_left = sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:  out_tready <= 1'b1;
      SINK_COIN:  out_tready <= ($urandom_range(0, 1) == 0);
      SINK_SLOW:  out_tready <= ($urandom_range(0, 5) == 0);
      default:    out_tready <= sink_left[2];
    endcase
  end

  // Monitor: predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    field_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        render_field(in_tdata, in_tuser);
        reqs_taken <= reqs_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %02h (last %0b)", out_tdata, out_tlast);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.ch) begin
            $error("out_char: expected %02h, actual %02h", want.ch, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_char: expected %0b, actual %0b", want.last, out_tlast);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("integer_field_formatter_core verification failed");
    $finish;
  end

  initial begin
    logic [VALUE_W-1:0] v;
    logic [CONV_W-1:0]  c;
    logic [WIDTH_W-1:0] w;
    logic [PREC_W-1:0]  p;

    // directed: extremes, every conversion and the corner cases
    queue_conv(32'd0,          CONV_DI,   6'd0,  PREC_ABSENT, 1'b0, 1'b0, 1'b0);
    queue_conv(32'd0,          CONV_DI,   6'd0,  7'd0,        1'b0, 1'b0, 1'b0);
    queue_conv(32'h8000_0000,  CONV_DI,   6'd0,  PREC_ABSENT, 1'b0, 1'b0, 1'b0);
    queue_conv(32'h7FFF_FFFF,  CONV_DI,   6'd63, PREC_ABSENT, 1'b0, 1'b1, 1'b0);
    queue_conv(32'hFFFF_FFFF,  CONV_DI,   6'd20, PREC_ABSENT, 1'b0, 1'b1, 1'b0);
    queue_conv(-32'd42,        CONV_DI,   6'd10, PREC_ABSENT, 1'b1, 1'b0, 1'b0);
    queue_conv(32'hFFFF_FFFF,  CONV_U,    6'd0,  7'd32,       1'b0, 1'b0, 1'b0);
    queue_conv(32'hDEAD_BEEF,  CONV_XLOW, 6'd12, 7'd10,       1'b0, 1'b0, 1'b0);
    queue_conv(32'hDEAD_BEEF,  CONV_XUP,  6'd12, PREC_ABSENT, 1'b0, 1'b1, 1'b0);
    queue_conv(32'hFFFF_FFFF,  CONV_OCT,  6'd63, PREC_ABSENT, 1'b1, 1'b0, 1'b0);
    queue_conv(32'd0,          CONV_PTR,  6'd40, 7'd5,        1'b1, 1'b1, 1'b0);
    queue_conv(32'hFFFF_FFFF,  CONV_PTR,  6'd0,  PREC_ABSENT, 1'b0, 1'b0, 1'b0);
    queue_conv(32'h1234_5678,  CONV_SPARE_LO, 6'd9, 7'd3,     1'b0, 1'b0, 1'b0);
    queue_conv(32'h1234_5678,  CONV_SPARE_HI, 6'd63, 7'd3,    1'b1, 1'b1, 1'b0);
    // drain the block right after an ignored conversion
    queue_conv(32'd77,         CONV_U,    6'd5,  7'h40,       1'b0, 1'b1, 1'b1);
    queue_conv(32'd1,          CONV_XLOW, 6'd0,  7'd63,       1'b0, 1'b0, 1'b0);
    queue_conv(32'hFFFF_FFFF,  CONV_OCT,  6'd0,  7'd33,       1'b1, 1'b0, 1'b0);
    queue_conv(32'd0,          CONV_U,    6'd63, 7'd0,        1'b0, 1'b0, 1'b0);
    queue_conv(-32'd7,         CONV_DI,   6'd8,  7'd4,        1'b0, 1'b1, 1'b0);
    queue_conv(-32'd7,         CONV_DI,   6'd8,  PREC_ABSENT, 1'b1, 1'b1, 1'b0);
    queue_conv(32'd0,          CONV_XUP,  6'd5,  7'd0,        1'b1, 1'b0, 1'b0);
    queue_conv(-32'd5,         CONV_DI,   6'd0,  7'd0,        1'b0, 1'b0, 1'b0);

    for (int i = 0; i < RANDOM_FIELDS; i++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(0, 31);
        2: v = $urandom_range(0, 20);
        3: v = -$urandom_range(1, 1000);
        default: begin
          case ($urandom_range(0, 4))
            0: v = 32'd0;
            1: v = 32'd1;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'h8000_0000;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
      endcase
      if ($urandom_range(0, 15) == 0)
        c = CONV_W'($urandom_range(CONV_SPARE_LO, CONV_SPARE_HI));
      else
        c = CONV_W'($urandom_range(0, CONV_PTR));
      w = ($urandom_range(0, 7) == 0) ? WIDTH_W'($urandom_range(0, MAX_FIELD))
                                      : WIDTH_W'($urandom_range(0, 16));
      case ($urandom_range(0, 3))
        0: p = {1'b1, 6'($urandom)};
        1: p = PREC_W'($urandom_range(0, 12));
        2: p = PREC_W'($urandom_range(0, 127));
        default: p = PREC_ABSENT;
      endcase
      queue_conv(v, c, w, p, 1'($urandom), 1'($urandom), $urandom_range(0, 39) == 0);
    end
    reqs_queued = pending_reqs.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (reqs_taken != reqs_queued) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && expected_chars.size() == 0)
      $display("integer_field_formatter_core verification clean");
    else
      $display("integer_field_formatter_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/ifmt_pkg.sv
design/ifmt_ctrl.sv
design/ifmt_dpath.sv
design/integer_field_formatter_core.sv
design/ifmt_chk.sv
dv/integer_field_formatter_core_tb.sv
